[rtl/core/load_cell_adc_reader_assert.svh]
// assertion macros shared by the load cell converter reader
`ifndef LOAD_CELL_ADC_READER_ASSERT_SVH
`define LOAD_CELL_ADC_READER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LCA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lca_pkg.sv]
// shared constants, codes and types of the load cell converter reader
package lca_pkg;

  localparam int DATA_BITS  = 24;
  localparam int TARE_READS = 10;
  localparam int PULSES     = DATA_BITS + 1;

  localparam int TICK_W    = 16;
  localparam int BIT_CNT_W = 5;
  localparam int READS_W   = 4;
  localparam int SUM_W     = DATA_BITS + READS_W;
  localparam int DIFF_W    = DATA_BITS + 1;
  localparam int SCALE_W   = 32;
  localparam int WEIGHT_W  = DIFF_W + SCALE_W;

  // floor(sum / TARE_READS) as (sum * TARE_RECIP) >> TARE_SHIFT, exact for every sum
  localparam int TARE_SHIFT = SUM_W + READS_W;
  localparam longint unsigned TARE_RECIP =
    ((64'd1 << TARE_SHIFT) + 64'(TARE_READS) - 64'd1) / 64'(TARE_READS);
  localparam int RECIP_W = $clog2(TARE_RECIP + 1);
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_PERIOD   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POWER_DOWN    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERSE_SCALE = 2'd2;

  localparam logic [TICK_W-1:0]        HALF_PERIOD_RST = 16'd50;
  localparam logic [TICK_W-1:0]        POWER_DOWN_RST  = 16'd3500;
  localparam logic signed [SCALE_W-1:0] SCALE_RST      = 32'sd65536;

  // action and event codes
  localparam int ACT_W = 3;
  localparam int EV_W  = 3;
  localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MEASURE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TARE       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POWER_DOWN = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POWER_UP   = 3'd4;
  localparam logic [EV_W-1:0]  EV_NONE        = 3'd0;
  localparam logic [EV_W-1:0]  EV_MEASURE     = 3'd1;
  localparam logic [EV_W-1:0]  EV_TARE        = 3'd2;
  localparam logic [EV_W-1:0]  EV_POWER_DOWN  = 3'd3;
  localparam logic [EV_W-1:0]  EV_POWER_UP    = 3'd4;

  // stream widths
  localparam int IN_TDATA_W    = 8;
  localparam int IN_TUSER_W    = ACT_W;
  localparam int OUT_FIELDS_W  = 2 + DATA_BITS + WEIGHT_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W   = EV_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_M_WAIT,
    PH_M_HIGH,
    PH_M_LOW,
    PH_T_WAIT,
    PH_T_HIGH,
    PH_T_LOW,
    PH_PD
  } phase_t;

  // one tick result as it leaves the sequencer
  typedef struct packed {
    logic                     clock_line;
    logic                     busy;
    logic [EV_W-1:0]          ev;
    logic [DATA_BITS-1:0]     raw;
    logic signed [DIFF_W-1:0] diff;
    logic [SUM_W-1:0]         sum;
  } seq_res_t;

endpackage

[rtl/core/load_cell_adc_reader.sv]
// top level of the load cell converter reader
//
// one input beat is one tick of the two-wire converter interface: s_tdata carries
// the sampled data line, s_tuser the requested action. every input beat yields
// exactly one output beat with the clock level to drive, the busy flag, the
// event code, the reading on a measure or tare completion and the weight on a
// measure completion. actions that arrive while a sequence runs are ignored.
// an input beat is registered, run through the pin sequencer into the sequencer
// result register, then through the weight multiply and tare average into the
// output register. while the receiver keeps m_tready high, throughput is one
// beat per cycle, set by the sequencer state update.
// when the receiver stalls, the three stages fill and s_tready drops; nothing
// is lost or repeated. reset (rst, synchronous) empties the pipeline, returns
// the sequencer to idle with the clock line low, clears the tare offset and
// loads the configuration defaults. the user writes the configuration through
// cfg_we, cfg_addr and cfg_wdata only while idle; the block does not enforce it.
`include "load_cell_adc_reader_assert.svh"

module load_cell_adc_reader (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [0] data_line, rest zero
  input  logic [lca_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [2:0] action
  input  logic [lca_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] clock_line, [1] busy_res, [25:2] raw_reading, [82:26] weight, rest zero
  output logic [lca_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // [2:0] event_res
  output logic [lca_pkg::OUT_TUSER_W-1:0]   m_tuser,
  input  logic                              cfg_we,
  input  logic [lca_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lca_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lca_pkg::*;

  // configuration registers
  logic [TICK_W-1:0]         half_period_ticks;
  logic [TICK_W-1:0]         power_down_ticks;
  logic signed [SCALE_W-1:0] inverse_scale;

  // input register
  logic             s1_valid;
  logic             s1_data_line;
  logic [ACT_W-1:0] s1_action;

  // sequencer result register
  logic     s2_valid;
  seq_res_t s2_res;

  logic s2_load, s2_take, take_ready, in_beat;

  logic                       out_clock_line, out_busy;
  logic [EV_W-1:0]            out_event;
  logic [DATA_BITS-1:0]       out_raw;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic [DATA_BITS-1:0]       tare_offset;

  // advance whenever the next stage is empty or emptying this cycle
  assign s2_take  = s2_valid && take_ready;
  assign s2_load  = s1_valid && (!s2_valid || take_ready);
  assign s_tready = !s1_valid || !s2_valid || take_ready;
  assign in_beat  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
      power_down_ticks  <= POWER_DOWN_RST;
      inverse_scale     <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HALF_PERIOD:   half_period_ticks <= cfg_wdata[TICK_W-1:0];
        CFG_POWER_DOWN:    power_down_ticks  <= cfg_wdata[TICK_W-1:0];
        CFG_INVERSE_SCALE: inverse_scale     <= $signed(cfg_wdata[SCALE_W-1:0]);
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_beat) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (s2_take) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_data_line <= s_tdata[0];
      s1_action    <= s_tuser;
    end
  end

  lca_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .step              (s2_load),
    .data_line         (s1_data_line),
    .action            (s1_action),
    .half_period_ticks (half_period_ticks),
    .power_down_ticks  (power_down_ticks),
    .tare_offset       (tare_offset),
    .res               (s2_res)
  );

  lca_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .take          (s2_take),
    .res           (s2_res),
    .inverse_scale (inverse_scale),
    .out_ready     (m_tready),
    .take_ready    (take_ready),
    .out_valid     (m_tvalid),
    .clock_line    (out_clock_line),
    .busy_res      (out_busy),
    .event_res     (out_event),
    .raw_reading   (out_raw),
    .weight        (out_weight),
    .tare_offset   (tare_offset)
  );

  // pack the result beat, first field in the lowest bits
  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                    out_weight, out_raw, out_busy, out_clock_line};
  assign m_tuser = out_event;

  // every completion event leaves the sequencer idle
  `LCA_ASSERT_SAME(a_event_not_busy, m_tvalid && (m_tuser != EV_NONE), !m_tdata[1], "event reported while busy")

  // weight is only nonzero on a measure completion
  `LCA_ASSERT_SAME(a_weight_only_measure, m_tvalid && (m_tuser != EV_MEASURE), out_weight == '0, "weight set outside measure completion")

  // the new tare offset is the value reported with the tare completion
  `LCA_ASSERT_NEXT(a_tare_offset_reported, s2_take && (s2_res.ev == EV_TARE), m_tvalid && (tare_offset == out_raw), "tare offset differs from reported value")

endmodule

[rtl/core/lca_seq.sv]
// pin sequencer: clock pulses, bit capture, tare accumulation, one result per tick
module lca_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          data_line,
  input  logic [lca_pkg::ACT_W-1:0]     action,
  input  logic [lca_pkg::TICK_W-1:0]    half_period_ticks,
  input  logic [lca_pkg::TICK_W-1:0]    power_down_ticks,
  input  logic [lca_pkg::DATA_BITS-1:0] tare_offset,
  output lca_pkg::seq_res_t             res
);
  import lca_pkg::*;

  phase_t                 phase, phase_next;
  logic [TICK_W-1:0]      tick_count, tick_count_next;
  logic [BIT_CNT_W-1:0]   bit_count, bit_count_next;
  logic [DATA_BITS-1:0]   shift_word, shift_word_next;
  logic [SUM_W-1:0]       tare_sum, tare_sum_next;
  logic [READS_W-1:0]     tare_reads_done, tare_reads_done_next;
  logic                   clock_level, clock_level_next;
  seq_res_t               res_next;

  logic [TICK_W-1:0]      half_len, pd_len;
  logic [BIT_CNT_W-1:0]   bit_inc;
  logic [DATA_BITS-1:0]   raw_word;
  logic [SUM_W-1:0]       sum_inc;
  logic [READS_W-1:0]     reads_inc;

  assign half_len  = (half_period_ticks == '0) ? TICK_W'(1) : half_period_ticks;
  assign pd_len    = (power_down_ticks == '0) ? TICK_W'(1) : power_down_ticks;
  assign bit_inc   = bit_count + BIT_CNT_W'(1);
  assign raw_word  = shift_word ^ TOP_BIT;
  assign sum_inc   = tare_sum + SUM_W'(raw_word);
  assign reads_inc = tare_reads_done + READS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= '0;
      bit_count       <= '0;
      shift_word      <= '0;
      tare_sum        <= '0;
      tare_reads_done <= '0;
      clock_level     <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      bit_count       <= bit_count_next;
      shift_word      <= shift_word_next;
      tare_sum        <= tare_sum_next;
      tare_reads_done <= tare_reads_done_next;
      clock_level     <= clock_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    bit_count_next       = bit_count;
    shift_word_next      = shift_word;
    tare_sum_next        = tare_sum;
    tare_reads_done_next = tare_reads_done;
    clock_level_next     = clock_level;
    res_next.ev          = EV_NONE;
    res_next.raw         = '0;
    res_next.diff        = '0;
    res_next.sum         = '0;

    unique case (phase)
      PH_IDLE: begin
        unique case (action)
          ACT_MEASURE: begin
            phase_next      = PH_M_WAIT;
            bit_count_next  = '0;
            shift_word_next = '0;
          end
          ACT_TARE: begin
            phase_next           = PH_T_WAIT;
            bit_count_next       = '0;
            shift_word_next      = '0;
            tare_sum_next        = '0;
            tare_reads_done_next = '0;
          end
          ACT_POWER_DOWN: begin
            clock_level_next = 1'b1;
            tick_count_next  = TICK_W'(1);
            phase_next       = PH_PD;
          end
          ACT_POWER_UP: begin
            clock_level_next = 1'b0;
            res_next.ev      = EV_POWER_UP;
          end
          default: begin
          end
        endcase
      end
      PH_M_WAIT, PH_T_WAIT: begin
        if (!data_line) begin
          clock_level_next = 1'b1;
          tick_count_next  = TICK_W'(1);
          bit_count_next   = '0;
          shift_word_next  = '0;
          phase_next       = (phase == PH_M_WAIT) ? PH_M_HIGH : PH_T_HIGH;
        end
      end
      PH_M_HIGH, PH_T_HIGH: begin
        if (tick_count >= half_len) begin
          // sample at the end of the high half, msb first
          if (bit_count < BIT_CNT_W'(DATA_BITS)) begin
            shift_word_next = {shift_word[DATA_BITS-2:0], data_line};
          end
          clock_level_next = 1'b0;
          tick_count_next  = TICK_W'(1);
          phase_next       = (phase == PH_M_HIGH) ? PH_M_LOW : PH_T_LOW;
        end else begin
          tick_count_next = tick_count + TICK_W'(1);
        end
      end
      PH_M_LOW, PH_T_LOW: begin
        if (tick_count >= half_len) begin
          bit_count_next = bit_inc;
          if (bit_inc < BIT_CNT_W'(PULSES)) begin
            clock_level_next = 1'b1;
            tick_count_next  = TICK_W'(1);
            phase_next       = (phase == PH_M_LOW) ? PH_M_HIGH : PH_T_HIGH;
          end else begin
            tick_count_next = '0;
            bit_count_next  = '0;
            if (phase == PH_M_LOW) begin
              res_next.ev   = EV_MEASURE;
              res_next.raw  = raw_word;
              res_next.diff = $signed({1'b0, raw_word}) - $signed({1'b0, tare_offset});
              phase_next    = PH_IDLE;
            end else begin
              tare_sum_next        = sum_inc;
              tare_reads_done_next = reads_inc;
              if (reads_inc >= READS_W'(TARE_READS)) begin
                res_next.ev  = EV_TARE;
                res_next.sum = sum_inc;
                phase_next   = PH_IDLE;
              end else begin
                shift_word_next = '0;
                phase_next      = PH_T_WAIT;
              end
            end
          end
        end else begin
          tick_count_next = tick_count + TICK_W'(1);
        end
      end
      PH_PD: begin
        if (tick_count >= pd_len) begin
          res_next.ev     = EV_POWER_DOWN;
          tick_count_next = '0;
          phase_next      = PH_IDLE;
        end else begin
          tick_count_next = tick_count + TICK_W'(1);
        end
      end
    endcase

    res_next.clock_line = clock_level_next;
    res_next.busy       = (phase_next != PH_IDLE);
  end

endmodule

[rtl/core/lca_calc.sv]
// result stage: weight multiply, tare average, tare offset and output register
module lca_calc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  lca_pkg::seq_res_t                   res,
  input  logic signed [lca_pkg::SCALE_W-1:0]  inverse_scale,
  input  logic                                out_ready,
  output logic                                take_ready,
  output logic                                out_valid,
  output logic                                clock_line,
  output logic                                busy_res,
  output logic [lca_pkg::EV_W-1:0]            event_res,
  output logic [lca_pkg::DATA_BITS-1:0]       raw_reading,
  output logic signed [lca_pkg::WEIGHT_W-1:0] weight,
  output logic [lca_pkg::DATA_BITS-1:0]       tare_offset
);
  import lca_pkg::*;

  logic signed [WEIGHT_W-1:0] product;
  logic [PROD_W-1:0]          avg_prod;
  logic [DATA_BITS-1:0]       tare_avg;

  assign product    = res.diff * inverse_scale;
  assign avg_prod   = PROD_W'(res.sum) * PROD_W'(TARE_RECIP);
  assign tare_avg   = avg_prod[TARE_SHIFT +: DATA_BITS];
  assign take_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      tare_offset <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take && res.ev == EV_TARE) begin
        tare_offset <= tare_avg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      clock_line  <= res.clock_line;
      busy_res    <= res.busy;
      event_res   <= res.ev;
      raw_reading <= (res.ev == EV_TARE) ? tare_avg : res.raw;
      weight      <= (res.ev == EV_MEASURE) ? product : '0;
    end
  end

endmodule
